>>> rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, constants and helpers shared by the format engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

   localparam int WIDTH_LIMIT  = 63;
   localparam int DIGIT_SLOTS  = 12;
   localparam int QUEUE_DEPTH  = 4;

   localparam int WIDTH_BITS   = $clog2(WIDTH_LIMIT + 1);
   localparam int SLOT_BITS    = $clog2(DIGIT_SLOTS);
   localparam int COUNT_BITS   = $clog2(DIGIT_SLOTS + 1);
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

   // Reciprocal of ten for a 32-bit dividend: q = (v * RECIP10) >> RECIP10_SHIFT.
   localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
   localparam int          RECIP10_SHIFT = 35;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_C = 8'h63;
   localparam logic [7:0] CH_LOWER_D = 8'h64;
   localparam logic [7:0] CH_LOWER_U = 8'h75;
   localparam logic [7:0] CH_LOWER_X = 8'h78;

   // Command kinds passed from the front to the back.
   localparam logic [1:0] CMD_CHAR = 2'd0;
   localparam logic [1:0] CMD_EOS  = 2'd1;
   localparam logic [1:0] CMD_DEC  = 2'd2;
   localparam logic [1:0] CMD_HEX  = 2'd3;

   typedef logic [WIDTH_BITS-1:0] pfe_width_type;

   typedef struct packed {
      logic [7:0]  format_char;
      logic [31:0] arg_value;
   } pfe_req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
      logic       end_of_string;
   } pfe_rsp_type;

   typedef struct packed {
      logic [1:0]    kind;
      logic [7:0]    char_val;
      logic [31:0]   value;
      logic          neg;
      logic          upper;
      logic          zero_pad;
      pfe_width_type width;
   } pfe_cmd_type;

   function automatic logic [7:0] pfe_digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] base;
      base = upper ? CH_UPPER_A : CH_LOWER_A;
      if (d < 4'd10) begin
         return CH_ZERO + {4'd0, d};
      end
      return base + {4'd0, d} - 8'd10;
   endfunction

endpackage

`default_nettype wire

>>> rtl/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front
// Parses format bytes, tracks the conversion spec and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 accept,
   input  pfe_pkg::pfe_req_type req,
   output logic                cmd_push,
   output pfe_pkg::pfe_cmd_type cmd
);
   import pfe_pkg::*;

   localparam logic [1:0] PH_LIT  = 2'd0;
   localparam logic [1:0] PH_OPEN = 2'd1;
   localparam logic [1:0] PH_SPEC = 2'd2;

   localparam int WIDE_BITS = WIDTH_BITS + 4;

   logic [1:0]          phase_ff, phase_in;
   logic                zero_pad_ff, zero_pad_in;
   pfe_width_type       width_ff, width_in;
   logic [WIDE_BITS-1:0] wide;
   logic [7:0]          ch;
   logic [31:0]         arg;

   assign ch  = req.format_char;
   assign arg = req.arg_value;

   // Width times ten plus the new digit.
   assign wide = WIDE_BITS'({width_ff, 3'b000}) + WIDE_BITS'({width_ff, 1'b0})
               + WIDE_BITS'(ch[3:0]);

   always_comb begin
      phase_in    = phase_ff;
      zero_pad_in = zero_pad_ff;
      width_in    = width_ff;
      cmd_push    = 1'b0;
      cmd.kind     = CMD_CHAR;
      cmd.char_val = ch;
      cmd.value    = arg;
      cmd.neg      = 1'b0;
      cmd.upper    = 1'b0;
      cmd.zero_pad = zero_pad_ff;
      cmd.width    = width_ff;
      if (accept) begin
         if (ch == CH_NUL) begin
            phase_in = PH_LIT;
            cmd_push = 1'b1;
            cmd.kind = CMD_EOS;
         end else if (phase_ff == PH_LIT) begin
            if (ch == CH_PERCENT) begin
               phase_in    = PH_OPEN;
               zero_pad_in = 1'b0;
               width_in    = '0;
            end else begin
               cmd_push = 1'b1;
            end
         end else if (phase_ff == PH_OPEN && ch == CH_ZERO) begin
            zero_pad_in = 1'b1;
            phase_in    = PH_SPEC;
         end else if (ch inside {[CH_ZERO:CH_NINE]}) begin
            phase_in = PH_SPEC;
            if (wide > WIDE_BITS'(WIDTH_LIMIT)) begin
               width_in = WIDTH_BITS'(WIDTH_LIMIT);
            end else begin
               width_in = wide[WIDTH_BITS-1:0];
            end
         end else begin
            phase_in = PH_LIT;
            case (ch)
               CH_LOWER_U: begin
                  cmd_push = 1'b1;
                  cmd.kind = CMD_DEC;
               end
               CH_LOWER_D: begin
                  cmd_push  = 1'b1;
                  cmd.kind  = CMD_DEC;
                  cmd.neg   = arg[31];
                  cmd.value = arg[31] ? (32'd0 - arg) : arg;
               end
               CH_LOWER_X: begin
                  cmd_push = 1'b1;
                  cmd.kind = CMD_HEX;
               end
               CH_UPPER_X: begin
                  cmd_push  = 1'b1;
                  cmd.kind  = CMD_HEX;
                  cmd.upper = 1'b1;
               end
               CH_LOWER_C: begin
                  cmd_push     = 1'b1;
                  cmd.char_val = arg[7:0];
               end
               CH_PERCENT: begin
                  cmd_push     = 1'b1;
                  cmd.char_val = CH_PERCENT;
               end
               default: begin
                  cmd_push = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LIT;
         zero_pad_ff <= 1'b0;
         width_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         zero_pad_ff <= zero_pad_in;
         width_ff    <= width_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/pfe_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pfe_cmd_fifo
// Short command queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_cmd_fifo (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  pfe_pkg::pfe_cmd_type push_data,
   output logic                 full,
   input  wire                  pop,
   output pfe_pkg::pfe_cmd_type head,
   output logic                 empty
);
   import pfe_pkg::*;

   pfe_cmd_type          slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS:0]   rd_ptr_ff, rd_ptr_in;
   logic                 do_push, do_pop;

   assign empty   = (wr_ptr_ff == rd_ptr_ff);
   assign full    = (wr_ptr_ff[QPTR_BITS] != rd_ptr_ff[QPTR_BITS])
                 && (wr_ptr_ff[QPTR_BITS-1:0] == rd_ptr_ff[QPTR_BITS-1:0]);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff[QPTR_BITS-1:0]];

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff[QPTR_BITS-1:0]] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back
// Runs commands: digit extraction, padding, one character a cycle if not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_back (
   input  wire                  clock,
   input  wire                  reset,
   input  pfe_pkg::pfe_cmd_type cmd,
   input  wire                  cmd_empty,
   output logic                 cmd_pop,
   output logic                 rsp_valid,
   output pfe_pkg::pfe_rsp_type rsp,
   input  wire                  rsp_take
);
   import pfe_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_HEX   = 3'd3;
   localparam logic [2:0] ST_PAD   = 3'd4;
   localparam logic [2:0] ST_SIGN  = 3'd5;
   localparam logic [2:0] ST_DIGIT = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [31:0]           value_ff, value_in;
   logic [63:0]           prod_ff, prod_in;
   logic                  neg_ff, neg_in;
   logic                  upper_ff, upper_in;
   logic                  zero_pad_ff, zero_pad_in;
   pfe_width_type         width_ff, width_in;
   pfe_width_type         pad_ff, pad_in;
   logic [COUNT_BITS-1:0] ndig_ff, ndig_in;
   logic [SLOT_BITS-1:0]  idx_ff, idx_in;
   logic [7:0]            digits_ff [DIGIT_SLOTS];
   logic                  rsp_valid_ff, rsp_valid_in;
   pfe_rsp_type           rsp_ff;

   logic                  out_free;
   logic                  emit;
   pfe_rsp_type           emit_data;
   logic                  wr_en;
   logic [3:0]            digit;
   logic [31:0]           quot;
   logic [31:0]           quot10;
   logic                  conv_done;
   pfe_width_type         text_len;
   pfe_width_type         pad_calc;

   assign out_free  = !rsp_valid_ff || rsp_take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign quot     = 32'(prod_ff[63:RECIP10_SHIFT]);
   assign quot10   = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
   // Length of the text: the digit being stored now, the earlier ones, the sign.
   assign text_len = WIDTH_BITS'(ndig_ff) + WIDTH_BITS'(1) + WIDTH_BITS'(neg_ff);
   assign pad_calc = (width_ff > text_len) ? (width_ff - text_len) : '0;

   always_comb begin
      state_in    = state_ff;
      value_in    = value_ff;
      prod_in     = prod_ff;
      neg_in      = neg_ff;
      upper_in    = upper_ff;
      zero_pad_in = zero_pad_ff;
      width_in    = width_ff;
      pad_in      = pad_ff;
      ndig_in     = ndig_ff;
      idx_in      = idx_ff;
      cmd_pop     = 1'b0;
      emit        = 1'b0;
      emit_data   = '0;
      wr_en       = 1'b0;
      digit       = value_ff[3:0];
      conv_done   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               case (cmd.kind)
                  CMD_CHAR, CMD_EOS: begin
                     if (out_free) begin
                        cmd_pop                 = 1'b1;
                        emit                    = 1'b1;
                        emit_data.out_char      = cmd.char_val;
                        emit_data.last          = 1'b1;
                        emit_data.end_of_string = (cmd.kind == CMD_EOS);
                     end
                  end
                  CMD_DEC, CMD_HEX: begin
                     cmd_pop     = 1'b1;
                     value_in    = cmd.value;
                     neg_in      = cmd.neg;
                     upper_in    = cmd.upper;
                     zero_pad_in = cmd.zero_pad;
                     width_in    = cmd.width;
                     ndig_in     = '0;
                     state_in    = (cmd.kind == CMD_DEC) ? ST_MUL : ST_HEX;
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_MUL: begin
            prod_in  = value_ff * RECIP10;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            digit     = 4'(value_ff - quot10);
            wr_en     = 1'b1;
            ndig_in   = ndig_ff + 1'b1;
            value_in  = quot;
            conv_done = (quot == 32'd0);
            state_in  = ST_MUL;
         end
         ST_HEX: begin
            digit     = value_ff[3:0];
            wr_en     = 1'b1;
            ndig_in   = ndig_ff + 1'b1;
            value_in  = {4'd0, value_ff[31:4]};
            conv_done = (value_ff[31:4] == 28'd0);
         end
         ST_PAD: begin
            if (out_free) begin
               emit               = 1'b1;
               emit_data.out_char = zero_pad_ff ? CH_ZERO : CH_SPACE;
               pad_in             = pad_ff - 1'b1;
               if (pad_ff == WIDTH_BITS'(1)) begin
                  state_in = neg_ff ? ST_SIGN : ST_DIGIT;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               emit               = 1'b1;
               emit_data.out_char = CH_MINUS;
               state_in           = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               emit               = 1'b1;
               emit_data.out_char = digits_ff[idx_ff];
               if (idx_ff == '0) begin
                  emit_data.last = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The most significant digit has just been stored: set up the emission.
      if (conv_done) begin
         idx_in = ndig_ff[SLOT_BITS-1:0];
         pad_in = pad_calc;
         if (pad_calc != '0) begin
            state_in = ST_PAD;
         end else if (neg_ff) begin
            state_in = ST_SIGN;
         end else begin
            state_in = ST_DIGIT;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         digits_ff[ndig_ff[SLOT_BITS-1:0]] <= pfe_digit_char(digit, upper_ff);
      end
      if (emit) begin
         rsp_ff <= emit_data;
      end
      value_ff    <= value_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      upper_ff    <= upper_in;
      zero_pad_ff <= zero_pad_in;
      width_ff    <= width_in;
      pad_ff      <= pad_in;
      ndig_ff     <= ndig_in;
      idx_ff      <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/printf_format_engine.sv
// ----------------------------------------------------------------------------
// printf_format_engine
// Byte-at-a-time printf-style formatter with a parser front and output back.
// ----------------------------------------------------------------------------
// The parser takes one format byte per cycle while its four-entry command
// queue has room; bytes that only open or extend a spec produce no output.
// The output sequencer sets the rate: a plain byte, %c, %% or the terminator
// goes out straight from its command. A conversion first takes its command;
// then each decimal digit is found by a multiply by the reciprocal of ten
// and a reduce step, and each hex digit is split off directly. The output
// characters (padding, sign, digits) then go out one by one, as fast as
// the result side takes them.
`default_nettype none

module printf_format_engine (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_push,
   output logic                  req_full,
   input  pfe_pkg::pfe_req_type  req_payload,
   output logic                  rsp_empty,
   input  wire                   rsp_pop,
   output pfe_pkg::pfe_rsp_type  rsp_payload
);
   import pfe_pkg::*;

   logic        queue_full;
   logic        queue_empty;
   logic        accept;
   logic        cmd_push;
   logic        cmd_pop;
   logic        rsp_valid;
   logic        rsp_take;
   pfe_cmd_type cmd_in;
   pfe_cmd_type cmd_head;

   assign req_full  = queue_full;
   assign accept    = req_push && !queue_full;
   assign rsp_empty = !rsp_valid;
   assign rsp_take  = rsp_pop && rsp_valid;

   pfe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_payload),
      .cmd_push (cmd_push),
      .cmd      (cmd_in)
   );

   pfe_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (queue_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (queue_empty)
   );

   pfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_head),
      .cmd_empty (queue_empty),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_payload),
      .rsp_take  (rsp_take)
   );

endmodule

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for printf_format_engine. Format bytes with argument words go in
// as requests. A predictor in the bench tracks the spec state and queues the
// characters it expects. Each popped character is compared field by field
// with the oldest queued one. Directed tests cover literals, every
// conversion and the spec corner cases. A random part then sends literal
// bytes and well-formed specs, with some broken ones and noise mixed in.
// Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import pfe_pkg::*;

   typedef enum logic [1:0] {
      PH_LITERAL,
      PH_OPENED,
      PH_WIDTH
   } fmt_phase_type;

   localparam logic [7:0] CH_UNKNOWN_Q = 8'h71;
   localparam int         FLUSH_CYCLES = 100;
   localparam int         DRAIN_LIMIT  = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   pfe_req_type req_payload = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   pfe_rsp_type rsp_payload;

   // Predictor state.
   fmt_phase_type spec_phase = PH_LITERAL;
   bit          pad_zero = 1'b0;
   int          spec_width = 0;
   pfe_rsp_type expected_chars[$];

   bit steady_flow = 1'b0;
   int error_count = 0;
   int requests_sent = 0;
   int chars_checked = 0;
   int numbers_converted = 0;
   int terminators_seen = 0;

   printf_format_engine u_top (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (error_count < 50) begin
         $display("tb: mismatch at %0t: %s", $realtime, what);
      end
      error_count++;
   endtask

   // Updates the spec state for one accepted request and queues the characters
   // that it must produce.
   function automatic void predict_format_byte(input logic [7:0] ch, input logic [31:0] arg);
      logic [7:0]  emitted[$];
      logic [7:0]  text[$];
      logic [7:0]  digit_ch;
      logic [31:0] mag;
      logic [3:0]  d;
      int          radix;
      int          w;
      bit          neg;
      bit          upper;
      bit          is_number;
      pfe_rsp_type r;

      if (ch == CH_NUL) begin
         spec_phase = PH_LITERAL;
         r.out_char = CH_NUL;
         r.last = 1'b1;
         r.end_of_string = 1'b1;
         expected_chars.push_back(r);
         terminators_seen++;
         return;
      end

      if (spec_phase == PH_LITERAL) begin
         if (ch == CH_PERCENT) begin
            spec_phase = PH_OPENED;
            pad_zero = 1'b0;
            spec_width = 0;
         end else begin
            emitted.push_back(ch);
         end
      end else if (spec_phase == PH_OPENED && ch == CH_ZERO) begin
         pad_zero = 1'b1;
         spec_phase = PH_WIDTH;
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
         w = spec_width * 10 + int'(ch - CH_ZERO);
         spec_width = (w > WIDTH_LIMIT) ? WIDTH_LIMIT : w;
         spec_phase = PH_WIDTH;
      end else begin
         spec_phase = PH_LITERAL;
         is_number = 1'b1;
         neg = 1'b0;
         upper = 1'b0;
         radix = 10;
         mag = arg;
         case (ch)
            CH_LOWER_U: ;
            CH_LOWER_D: begin
               if (arg[31]) begin
                  neg = 1'b1;
                  mag = -arg;
               end
            end
            CH_LOWER_X: radix = 16;
            CH_UPPER_X: begin
               radix = 16;
               upper = 1'b1;
            end
            CH_LOWER_C: begin
               emitted.push_back(arg[7:0]);
               is_number = 1'b0;
            end
            CH_PERCENT: begin
               emitted.push_back(CH_PERCENT);
               is_number = 1'b0;
            end
            default: is_number = 1'b0;
         endcase
         if (is_number) begin
            numbers_converted++;
            do begin
               d = 4'(mag % radix);
               mag = mag / radix;
               if (d < 10) begin
                  digit_ch = CH_ZERO + {4'd0, d};
               end else begin
                  digit_ch = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'd0, d} - 8'd10;
               end
               text.push_front(digit_ch);
            end while (mag != 0);
            if (neg) begin
               text.push_front(CH_MINUS);
            end
            // Padding goes ahead of the sign as well as the digits.
            for (int i = text.size(); i < spec_width; i++) begin
               emitted.push_back(pad_zero ? CH_ZERO : CH_SPACE);
            end
            foreach (text[i]) begin
               emitted.push_back(text[i]);
            end
         end
      end

      foreach (emitted[i]) begin
         r.out_char = emitted[i];
         r.last = (i == emitted.size() - 1);
         r.end_of_string = 1'b0;
         expected_chars.push_back(r);
      end
   endfunction

   // Sends one request. The valid is only lowered when a gap is drawn, so a
   // back-to-back request keeps it high.
   task automatic push_format_byte(input logic [7:0] ch, input logic [31:0] arg);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 16);
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_payload <= '{format_char: ch, arg_value: arg};
      do @(posedge clock); while (req_full);
      predict_format_byte(ch, arg);
      requests_sent++;
   endtask

   function automatic logic [31:0] random_argument();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 99);
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h8000_0000;
               default: return 32'h7FFF_FFFF;
            endcase
         end
         3: return -$urandom_range(1, 1000);
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic test_literals();
      push_format_byte(CH_UPPER_A, 32'h0000_0000);
      push_format_byte(8'hFF, 32'hFFFF_FFFF);
      push_format_byte(CH_NUL, $urandom);
   endtask

   task automatic test_decimal();
      push_format_byte(CH_PERCENT, $urandom);
      push_format_byte(CH_LOWER_U, 32'hFFFF_FFFF);
      // The most negative value must print its whole magnitude.
      push_format_byte(CH_PERCENT, $urandom);
      push_format_byte(CH_LOWER_D, 32'h8000_0000);
      // Zero padding of a negative number lands in front of the sign.
      push_format_byte(CH_PERCENT, $urandom);
      push_format_byte(CH_ZERO, $urandom);
      push_format_byte(CH_ZERO + 8'd5, $urandom);
      push_format_byte(CH_LOWER_D, -32'sd5);
   endtask

   task automatic test_hex();
      // A width equal to the text length adds no padding.
      push_format_byte(CH_PERCENT, $urandom);
      push_format_byte(CH_ZERO + 8'd1, $urandom);
      push_format_byte(CH_LOWER_X, 32'h0000_0000);
      // Width 99 saturates at the limit.
      push_format_byte(CH_PERCENT, $urandom);
      push_format_byte(CH_NINE, $urandom);
      push_format_byte(CH_NINE, $urandom);
      push_format_byte(CH_UPPER_X, 32'hDEAD_BEEF);
   endtask

   task automatic test_char_and_percent();
      // Width has no effect on a character; a doubled percent gives a percent sign.
      push_format_byte(CH_PERCENT, $urandom);
      push_format_byte(CH_ZERO + 8'd3, $urandom);
      push_format_byte(CH_LOWER_C, 32'h1234_565A);
      push_format_byte(CH_PERCENT, $urandom);
      push_format_byte(CH_PERCENT, $urandom);
   endtask

   task automatic test_spec_edge_cases();
      push_format_byte(CH_PERCENT, $urandom);
      push_format_byte(CH_UNKNOWN_Q, $urandom);
      // A terminator inside a spec ends both the spec and the string.
      push_format_byte(CH_PERCENT, $urandom);
      push_format_byte(CH_ZERO + 8'd4, $urandom);
      push_format_byte(CH_NUL, $urandom);
   endtask

   task automatic test_random_strings();
      logic [7:0] conv_codes [6];
      int         first_request;
      int         kind;
      int         ndig;
      int         pick;
      conv_codes = '{CH_LOWER_U, CH_LOWER_D, CH_LOWER_X, CH_UPPER_X, CH_LOWER_C, CH_PERCENT};
      first_request = requests_sent;
      steady_flow = 1'b0;
      while (requests_sent - first_request < 92) begin
         if ($urandom_range(0, 7) == 0) begin
            steady_flow = !steady_flow;
         end
         kind = $urandom_range(0, 9);
         if (kind <= 2) begin
            push_format_byte(8'($urandom_range(1, 255)), $urandom);
         end else if (kind <= 8) begin
            push_format_byte(CH_PERCENT, $urandom);
            if ($urandom_range(0, 1) == 1) begin
               push_format_byte(CH_ZERO, $urandom);
            end
            pick = $urandom_range(0, 19);
            ndig = (pick < 5) ? 0 : (pick < 15) ? 1 : (pick < 19) ? 2 : 3;
            repeat (ndig) push_format_byte(CH_ZERO + 8'($urandom_range(0, 9)), $urandom);
            if (kind == 8) begin
               // Broken spec: a terminator or an arbitrary byte in place of
               // the conversion.
               push_format_byte($urandom_range(0, 1) ? CH_NUL : 8'($urandom_range(0, 255)),
                                random_argument());
            end else begin
               push_format_byte(conv_codes[$urandom_range(0, 5)], random_argument());
            end
         end else begin
            push_format_byte(8'($urandom_range(0, 255)), $urandom);
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin : result_checker
      int          stall;
      pfe_rsp_type want;
      @(negedge reset);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 16);
         @(negedge clock);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character %h", rsp_payload.out_char));
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_payload.out_char !== want.out_char) begin
               report_mismatch($sformatf("out_char %h, expected %h",
                                         rsp_payload.out_char, want.out_char));
            end
            if (rsp_payload.last !== want.last) begin
               report_mismatch($sformatf("last %b, expected %b",
                                         rsp_payload.last, want.last));
            end
            if (rsp_payload.end_of_string !== want.end_of_string) begin
               report_mismatch($sformatf("end_of_string %b, expected %b",
                                         rsp_payload.end_of_string, want.end_of_string));
            end
         end
      end
   end

   initial begin
      int drain_cycles;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_literals();
      test_decimal();
      test_hex();
      test_char_and_percent();
      test_spec_edge_cases();
      test_random_strings();

      @(negedge clock);
      req_push <= 1'b0;

      drain_cycles = 0;
      while (expected_chars.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0) begin
         report_mismatch($sformatf("%0d expected characters never arrived",
                                   expected_chars.size()));
      end

      $display("tb: %0d requests sent, %0d characters checked, %0d errors",
               requests_sent, chars_checked, error_count);
      $display("tb: %0d numeric conversions and %0d terminators predicted",
               numbers_converted, terminators_seen);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: timeout");
      $display("tb: done, errors");
      $finish;
   end

endmodule
